### hdl/tssp_pkg.sv
// Package for the trace state subkey parser: item types, segment state and character codes.
package tssp_pkg;

    // Number of hex digits in a full 56-bit value and the accumulator width.
    localparam int HEX_DIGITS = 14;
    localparam int ACC_W      = 4 * HEX_DIGITS;
    localparam int TOP_SHIFT  = 4 * (HEX_DIGITS - 1);

    // Character codes the parser reacts to.
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_H     = 8'h68;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_V     = 8'h76;

    // Saturation limit of the extra segment counter.
    localparam logic [7:0] SEG_CNT_MAX = 8'hFF;

    // One input item.
    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic             threshold_found;
        logic [ACC_W-1:0] threshold_bits;
        logic             random_found;
        logic [ACC_W-1:0] random_word;
        logic [7:0]       extra_segments;
        logic             length_exceeded;
    } t_out_item;

    // Classification of one character, produced by the decoder.
    typedef struct packed {
        logic       is_semi;
        logic       is_colon;
        logic       is_hex;
        logic [3:0] nib;
        logic       is_t;
        logic       is_h;
        logic       is_r;
        logic       is_v;
    } t_char_class;

    // Per-segment parse state.
    typedef struct packed {
        logic             in_value;
        logic [1:0]       key_len;
        logic             m_th;
        logic             m_rv;
        logic [3:0]       dcnt;
        logic [ACC_W-1:0] accum;
        logic             dvalid;
    } t_seg;

    // Results collected over the whole string.
    typedef struct packed {
        logic             have_th;
        logic [ACC_W-1:0] th;
        logic             have_rv;
        logic [ACC_W-1:0] rv;
        logic [7:0]       seg_cnt;
    } t_glob;

    localparam t_seg SEG_CLEAR = '{
        in_value: 1'b0,
        key_len:  2'd0,
        m_th:     1'b1,
        m_rv:     1'b1,
        dcnt:     4'd0,
        accum:    '0,
        dvalid:   1'b1
    };

    localparam t_glob GLOB_CLEAR = '{
        have_th: 1'b0,
        th:      '0,
        have_rv: 1'b0,
        rv:      '0,
        seg_cnt: 8'd0
    };

endpackage

### hdl/tssp_char_decode.sv
// Character decoder: classifies one byte as separator, key letter or lowercase hex digit.
module tssp_char_decode
    import tssp_pkg::*;
(
    input  logic [7:0]  i_char,
    output t_char_class o_class
);

    // Separators and key letters are plain compares; hex digits map to a nibble.
    always_comb begin
        o_class          = '0;
        o_class.is_semi  = (i_char == CHAR_SEMI);
        o_class.is_colon = (i_char == CHAR_COLON);
        o_class.is_t     = (i_char == CHAR_T);
        o_class.is_h     = (i_char == CHAR_H);
        o_class.is_r     = (i_char == CHAR_R);
        o_class.is_v     = (i_char == CHAR_V);
        if (i_char inside {[8'h30:8'h39]}) begin
            o_class.is_hex = 1'b1;
            o_class.nib    = i_char[3:0];
        end else if (i_char inside {[8'h61:8'h66]}) begin
            o_class.is_hex = 1'b1;
            o_class.nib    = i_char[3:0] + 4'd9;
        end
    end

endmodule

### hdl/trace_state_subkey_parser.sv
// Top level of the trace state subkey parser: handshake, parse state and result register.
//
// The parser takes one character item per clock cycle while the input side is not stalled.
// An accepted item is held in an input register, is folded into the segment state by a
// single pass of compare and nibble logic, and on the last character of a string the
// result item is loaded into the output register. The input side stalls only when the
// output register holds an undelivered result that the receiver is stalling and the
// input register is occupied. After each result the parse state returns to its reset
// values, so the next string can follow immediately. Strings longer than MAX_LENGTH
// characters give an all-zero result with length_exceeded set.
module trace_state_subkey_parser
    import tssp_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 2);

    // Close a segment: store a well-formed th or rv value, or count another keyed segment.
    function automatic t_glob close_seg(input t_seg s, input t_glob g);
        t_glob r;
        logic  two;
        r   = g;
        two = (s.key_len == 2'd2);
        if (s.in_value) begin
            if (two && s.m_th) begin
                if (s.dvalid && (s.dcnt <= 4'(HEX_DIGITS))) begin
                    r.have_th = 1'b1;
                    r.th      = s.accum;
                end
            end else if (two && s.m_rv) begin
                if (s.dvalid && (s.dcnt == 4'(HEX_DIGITS))) begin
                    r.have_rv = 1'b1;
                    r.rv      = s.accum;
                end
            end else if (g.seg_cnt != SEG_CNT_MAX) begin
                r.seg_cnt = g.seg_cnt + 8'd1;
            end
        end
        return r;
    endfunction

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [CNT_W-1:0]  r_char_count;
    logic [CNT_W-1:0]  n_char_count;
    t_seg              r_seg;
    t_seg              n_seg;
    t_glob             r_glob;
    t_glob             n_glob;
    t_out_item         n_out;
    t_char_class       w_class;
    logic              w_ready_out;
    logic              w_proc;

    // Handshake: the input register advances whenever the result register can move.
    assign w_ready_out = !r_out_valid || !i_out_stall;
    assign w_proc      = r_in_valid && w_ready_out;
    assign o_in_stall  = r_in_valid && !w_ready_out;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    tssp_char_decode u_decode (
        .i_char  (r_in.char_code),
        .o_class (w_class)
    );

    // Fold the registered character into the parse state and build the result.
    always_comb begin
        t_seg       seg;
        t_glob      glob;
        t_glob      glob_fin;
        logic [CNT_W-1:0] cnt;

        cnt = r_char_count;
        if (r_char_count < CNT_W'(MAX_LENGTH + 1)) begin
            cnt = r_char_count + CNT_W'(1);
        end

        seg  = r_seg;
        glob = r_glob;
        if (w_class.is_semi) begin
            glob = close_seg(r_seg, r_glob);
            seg  = SEG_CLEAR;
        end else if (!r_seg.in_value) begin
            if (w_class.is_colon) begin
                seg.in_value = 1'b1;
            end else begin
                case (r_seg.key_len)
                    2'd0: begin
                        seg.m_th = r_seg.m_th && w_class.is_t;
                        seg.m_rv = r_seg.m_rv && w_class.is_r;
                    end
                    2'd1: begin
                        seg.m_th = r_seg.m_th && w_class.is_h;
                        seg.m_rv = r_seg.m_rv && w_class.is_v;
                    end
                    default: begin
                        seg.m_th = 1'b0;
                        seg.m_rv = 1'b0;
                    end
                endcase
                if (r_seg.key_len != 2'd3) begin
                    seg.key_len = r_seg.key_len + 2'd1;
                end
            end
        end else begin
            if (!w_class.is_hex) begin
                seg.dvalid = 1'b0;
            end
            if (w_class.is_hex && (r_seg.dcnt < 4'(HEX_DIGITS))) begin
                seg.accum = r_seg.accum
                          | (ACC_W'(w_class.nib) << (6'(TOP_SHIFT) - {r_seg.dcnt, 2'b00}));
            end
            if (r_seg.dcnt != 4'd15) begin
                seg.dcnt = r_seg.dcnt + 4'd1;
            end
        end

        glob_fin = close_seg(seg, glob);

        // Result item, cleared when the string ran over the length limit.
        n_out = '0;
        if (cnt > CNT_W'(MAX_LENGTH)) begin
            n_out.length_exceeded = 1'b1;
        end else begin
            n_out.threshold_found = glob_fin.have_th;
            n_out.threshold_bits  = glob_fin.th;
            n_out.random_found    = glob_fin.have_rv;
            n_out.random_word     = glob_fin.rv;
            n_out.extra_segments  = glob_fin.seg_cnt;
        end

        // The last character returns all parse state to its reset values.
        if (r_in.final_char) begin
            n_char_count = '0;
            n_seg        = SEG_CLEAR;
            n_glob       = GLOB_CLEAR;
        end else begin
            n_char_count = cnt;
            n_seg        = seg;
            n_glob       = glob;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Parse state, updated once for each processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_seg        <= SEG_CLEAR;
            r_glob       <= GLOB_CLEAR;
        end else if (w_proc) begin
            r_char_count <= n_char_count;
            r_seg        <= n_seg;
            r_glob       <= n_glob;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready_out) begin
            r_out_valid <= w_proc && r_in.final_char;
        end
        if (w_proc && r_in.final_char) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    // The input side only stalls behind a pending, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a pending stalled result");

    // A string that ran over the limit delivers no parsed fields.
    a_overflow_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.length_exceeded) |->
            (!o_out_item.threshold_found && !o_out_item.random_found &&
             (o_out_item.extra_segments == 8'd0)))
        else $error("overflow result carries parsed fields");

    // A threshold value is only ever stored together with its found flag.
    a_threshold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.threshold_found) |->
            (o_out_item.threshold_bits == '0))
        else $error("threshold value without found flag");

    // After the last character the parse state is back at reset.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.final_char) |=>
            ((r_char_count == '0) && (r_glob == GLOB_CLEAR) && (r_seg == SEG_CLEAR)))
        else $error("parse state not cleared after last character");
`endif

endmodule
